[rtl/float_to_decimal_text_defines.svh]
// Assertion helpers for the ftdt_datapath RTL
`ifndef FLOAT_TO_DECIMAL_TEXT_DEFINES_SVH
`define FLOAT_TO_DECIMAL_TEXT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FTDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FTDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ftdt_pkg.sv]
package ftdt_pkg;

  localparam int MANT_W      = 24;
  localparam int EXP_W       = 10;
  localparam int DIGIT_SLOTS = 19;
  localparam int ND_W        = $clog2(DIGIT_SLOTS + 1);
  localparam int Q_W         = 31;
  localparam int FD_W        = 4;
  localparam int EX_W        = 7;

  localparam logic [FD_W-1:0] FD_MAX = 4'd9;

  // normalized float: value = mant * 2^(exp-23), mant[23] set
  localparam logic [MANT_W-1:0]        TEN_MANT    = 24'hA00000;
  localparam logic signed [EXP_W-1:0]  TEN_EXP     = 10'sd3;
  localparam logic [MANT_W-1:0]        TENTH_MANT  = 24'hCCCCCD;
  localparam logic signed [EXP_W-1:0]  TENTH_EXP   = -10'sd4;
  localparam logic [MANT_W-1:0]        ONE_MANT    = 24'h800000;
  localparam logic signed [EXP_W-1:0]  ONE_EXP     = 10'sd0;
  // 2.147484e9f rounds to 2^31 + 256
  localparam logic [MANT_W-1:0]        LIMIT_MANT  = 24'h800001;
  localparam logic signed [EXP_W-1:0]  LIMIT_EXP   = 10'sd31;
  localparam logic signed [EXP_W-1:0]  MIN_NORM_EXP = -10'sd126;
  localparam logic signed [EXP_W-1:0]  BIAS        = 10'sd127;

  localparam logic [31:0]      RECIP10 = 32'hCCCCCCCD;
  localparam logic [Q_W-1:0]   Q_SAT   = 31'h7FFFFFFF;

  localparam logic [6:0] ASC_ZERO  = 7'h30;
  localparam logic [6:0] ASC_MINUS = 7'h2D;
  localparam logic [6:0] ASC_DOT   = 7'h2E;
  localparam logic [6:0] ASC_E     = 7'h65;

  localparam logic [ND_W-1:0] ERR_LAST = 5'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PRE, ST_DN_A, ST_DN_B, ST_UP_A, ST_UP_B, ST_SC_A, ST_SC_B, ST_QC,
    ST_DV_A, ST_DV_B, ST_SIGN, ST_DIG, ST_DOT, ST_EXP_E, ST_EXP_S, ST_EXP_T,
    ST_EXP_O, ST_ERR
  } state_t;

  typedef enum logic [1:0] {MUL_TEN, MUL_TENTH, MUL_SCALE} mul_sel_t;

  typedef enum logic [2:0] {
    CH_MINUS, CH_DIGIT, CH_DOT, CH_E, CH_TENS, CH_ONES, CH_ERR
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      shift;
    logic      mul_load;
    logic      ex_inc;
    logic      ex_dec;
    logic      set_exp;
    logic      q_load;
    logic      div_step;
    logic      ptr_init;
    logic      ptr_dec;
    logic      ptr_clr;
    logic      ptr_inc;
    logic      emit;
    logic      last;
    mul_sel_t  mul_sel;
    char_sel_t char_sel;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic zero;
    logic unnorm;
    logic sci;
    logic lt_tenth;
    logic ge_ten;
    logic lt_one;
    logic p_err;
    logic div_more;
    logic neg;
    logic ptr_is_fd;
    logic ptr_zero;
    logic fd_zero;
    logic use_exp;
    logic ex_neg;
    logic ex_ge10;
    logic err_end;
    logic out_free;
  } status_t;

  function automatic logic fl_lt(input logic [MANT_W-1:0] am,
                                 input logic signed [EXP_W-1:0] ae,
                                 input logic [MANT_W-1:0] bm,
                                 input logic signed [EXP_W-1:0] be);
    return (ae < be) || ((ae == be) && (am < bm));
  endfunction

  function automatic logic [MANT_W-1:0] pow10_mant(input logic [FD_W-1:0] k);
    logic [MANT_W-1:0] r;
    unique case (k)
      4'd0:    r = 24'h800000;
      4'd1:    r = 24'hA00000;
      4'd2:    r = 24'hC80000;
      4'd3:    r = 24'hFA0000;
      4'd4:    r = 24'h9C4000;
      4'd5:    r = 24'hC35000;
      4'd6:    r = 24'hF42400;
      4'd7:    r = 24'h989680;
      4'd8:    r = 24'hBEBC20;
      default: r = 24'hEE6B28;
    endcase
    return r;
  endfunction

  function automatic logic signed [EXP_W-1:0] pow10_exp(input logic [FD_W-1:0] k);
    logic signed [EXP_W-1:0] r;
    unique case (k)
      4'd0:    r = 10'sd0;
      4'd1:    r = 10'sd3;
      4'd2:    r = 10'sd6;
      4'd3:    r = 10'sd9;
      4'd4:    r = 10'sd13;
      4'd5:    r = 10'sd16;
      4'd6:    r = 10'sd19;
      4'd7:    r = 10'sd23;
      4'd8:    r = 10'sd26;
      default: r = 10'sd29;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] err_char(input logic [2:0] idx);
    logic [6:0] c;
    unique case (idx)
      3'd0:    c = 7'h45;
      3'd1:    c = 7'h52;
      3'd2:    c = 7'h52;
      3'd3:    c = 7'h4F;
      default: c = 7'h52;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] tens_of(input logic [5:0] a);
    logic [3:0] t;
    priority if (a >= 6'd60) t = 4'd6;
    else if (a >= 6'd50) t = 4'd5;
    else if (a >= 6'd40) t = 4'd4;
    else if (a >= 6'd30) t = 4'd3;
    else if (a >= 6'd20) t = 4'd2;
    else if (a >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

endpackage

[rtl/float_to_decimal_text.sv]
// Formats one single-precision value as ASCII text, one character per output
// beat with tlast on the final one. A value is taken only while the block is
// between numbers, so one value is in work at a time. The steps are: load,
// classify and shift a subnormal input until it is normalized, multiply by 10
// or 0.1 (scientific mode, up to 45 of them) until the loop ends, scale by
// 10^digits, round, split off the decimal digits (up to 10) by repeated
// divide-by-ten, fill the sign slot (which also sends a minus), then send the
// remaining characters (up to 16 characters in all), each held while the
// output slot is full. The shared float multiplier and the divide-by-ten
// step are both registered.
module float_to_decimal_text (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value_bits[31:0], frac_digits[35:32], sci_mode[36], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // char_code[6:0], zero pad
  output logic        out_tlast   // last
);

  ftdt_pkg::cmd_t    cmd;
  ftdt_pkg::status_t sts;

  ftdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ftdt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[rtl/ftdt_fmul.sv]
module ftdt_fmul (
  input  logic                                clk,
  input  logic [ftdt_pkg::MANT_W-1:0]         a_mant,
  input  logic signed [ftdt_pkg::EXP_W-1:0]   a_exp,
  input  logic [ftdt_pkg::MANT_W-1:0]         b_mant,
  input  logic signed [ftdt_pkg::EXP_W-1:0]   b_exp,
  output logic [ftdt_pkg::MANT_W-1:0]         r_mant,
  output logic signed [ftdt_pkg::EXP_W-1:0]   r_exp
);

  logic [2*ftdt_pkg::MANT_W-1:0]       prod_r;
  logic signed [ftdt_pkg::EXP_W-1:0]   esum_r;

  always_ff @(posedge clk) begin
    prod_r <= a_mant * b_mant;
    esum_r <= a_exp + b_exp;
  end

  logic [48:0]                         w, unit, lowmask, y;
  logic signed [ftdt_pkg::EXP_W-1:0]   e_n, diff;
  logic [5:0]                          k, l;
  logic                                g, s, lb, up;

  // round to nearest even; below the normal range the round point moves up
  always_comb begin
    if (prod_r[47]) begin
      w   = {1'b0, prod_r};
      e_n = esum_r + 10'sd1;
    end else begin
      w   = {1'b0, prod_r[46:0], 1'b0};
      e_n = esum_r;
    end
    diff = ftdt_pkg::MIN_NORM_EXP - e_n;
    if (e_n >= ftdt_pkg::MIN_NORM_EXP) k = 6'd0;
    else if (diff > 10'sd24) k = 6'd24;
    else k = diff[5:0];
    l       = 6'd24 + k;
    unit    = 49'd1 << l;
    lowmask = unit - 49'd1;
    g       = |(w & (unit >> 1));
    s       = |(w & (lowmask >> 1));
    lb      = |(w & unit);
    up      = g & (s | lb);
    y       = (w & ~lowmask) + (up ? unit : 49'd0);
    if (y[48]) begin
      r_mant = y[48:25];
      r_exp  = e_n + 10'sd1;
    end else begin
      r_mant = y[47:24];
      r_exp  = e_n;
    end
  end

endmodule

[rtl/ftdt_datapath.sv]
`include "float_to_decimal_text_defines.svh"

module ftdt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [39:0]         in_tdata,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  input  ftdt_pkg::cmd_t      cmd,
  output ftdt_pkg::status_t   sts
);

  logic [ftdt_pkg::MANT_W-1:0]        m_mant_r;
  logic signed [ftdt_pkg::EXP_W-1:0]  m_exp_r;
  logic                               zero_r, neg_r, special_r, sci_r, use_exp_r;
  logic [ftdt_pkg::FD_W-1:0]          fd_r;
  logic signed [ftdt_pkg::EX_W-1:0]   ex_r;
  logic [ftdt_pkg::Q_W-1:0]           q_r;
  logic [ftdt_pkg::ND_W-1:0]          nd_r, ptr_r;
  logic [3:0]                         dg_r [ftdt_pkg::DIGIT_SLOTS];
  logic [63:0]                        dprod_r;
  logic                               out_valid_r, out_last_r;
  logic [6:0]                         out_char_r;

  logic [7:0]  ld_efield;
  logic [22:0] ld_frac;
  logic [3:0]  ld_fd;
  assign ld_efield = in_tdata[30:23];
  assign ld_frac   = in_tdata[22:0];
  assign ld_fd     = in_tdata[35:32];

  logic [ftdt_pkg::MANT_W-1:0]        b_mant, mul_mant;
  logic signed [ftdt_pkg::EXP_W-1:0]  b_exp, mul_exp;

  always_comb begin
    unique case (cmd.mul_sel)
      ftdt_pkg::MUL_TEN: begin
        b_mant = ftdt_pkg::TEN_MANT;
        b_exp  = ftdt_pkg::TEN_EXP;
      end
      ftdt_pkg::MUL_TENTH: begin
        b_mant = ftdt_pkg::TENTH_MANT;
        b_exp  = ftdt_pkg::TENTH_EXP;
      end
      default: begin
        b_mant = ftdt_pkg::pow10_mant(fd_r);
        b_exp  = ftdt_pkg::pow10_exp(fd_r);
      end
    endcase
  end

  ftdt_fmul u_fmul (
    .clk    (clk),
    .a_mant (m_mant_r),
    .a_exp  (m_exp_r),
    .b_mant (b_mant),
    .b_exp  (b_exp),
    .r_mant (mul_mant),
    .r_exp  (mul_exp)
  );

  // rounded integer of the scaled product, half up
  logic [ftdt_pkg::Q_W-1:0] q_new;
  logic [24:0]              ext;
  logic [4:0]               sh;
  always_comb begin
    sh  = 5'(10'sd23 - m_exp_r);
    ext = {m_mant_r, 1'b0} >> sh;
    priority if (zero_r) q_new = '0;
    else if (m_exp_r >= 10'sd31) q_new = ftdt_pkg::Q_SAT;
    else if (m_exp_r >= 10'sd23)
      q_new = {7'd0, m_mant_r} << 3'(m_exp_r - 10'sd23);
    else if (m_exp_r >= -10'sd1)
      q_new = 31'(ext[24:1]) + 31'(ext[0]);
    else q_new = '0;
  end

  // divide by ten through the registered reciprocal product
  logic [28:0] quot;
  logic [3:0]  digit;
  assign quot  = dprod_r[63:35];
  assign digit = 4'(q_r - 31'({quot, 3'b000} + {quot, 1'b0}));

  logic [5:0] ex_abs;
  logic [3:0] ex_tens, ex_ones;
  assign ex_abs  = ex_r[ftdt_pkg::EX_W-1] ? 6'(-ex_r) : 6'(ex_r);
  assign ex_tens = ftdt_pkg::tens_of(ex_abs);
  assign ex_ones = 4'(ex_abs - 6'({ex_tens, 3'b000} + {ex_tens, 1'b0}));

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    dprod_r <= {1'b0, q_r} * ftdt_pkg::RECIP10;
    if (cmd.load) begin
      special_r <= (ld_efield == 8'hFF);
      zero_r    <= (ld_efield == 8'd0) && (ld_frac == 23'd0);
      neg_r     <= in_tdata[31] && !((ld_efield == 8'd0) && (ld_frac == 23'd0));
      m_mant_r  <= {ld_efield != 8'd0, ld_frac};
      m_exp_r   <= (ld_efield == 8'd0) ? ftdt_pkg::MIN_NORM_EXP
                                       : 10'($signed({2'b00, ld_efield})) - ftdt_pkg::BIAS;
      fd_r      <= (ld_fd > ftdt_pkg::FD_MAX) ? ftdt_pkg::FD_MAX : ld_fd;
      sci_r     <= in_tdata[36];
      use_exp_r <= 1'b0;
      ex_r      <= '0;
      nd_r      <= '0;
    end
    if (cmd.shift) begin
      m_mant_r <= {m_mant_r[ftdt_pkg::MANT_W-2:0], 1'b0};
      m_exp_r  <= m_exp_r - 10'sd1;
    end
    if (cmd.mul_load) begin
      m_mant_r <= mul_mant;
      m_exp_r  <= mul_exp;
    end
    if (cmd.ex_inc) ex_r <= ex_r + 7'sd1;
    if (cmd.ex_dec) ex_r <= ex_r - 7'sd1;
    if (cmd.set_exp) use_exp_r <= 1'b1;
    if (cmd.q_load) q_r <= q_new;
    if (cmd.div_step) begin
      dg_r[nd_r] <= digit;
      nd_r       <= nd_r + 5'd1;
      q_r        <= 31'(quot);
    end
    if (cmd.ptr_init) ptr_r <= nd_r - 5'd1;
    if (cmd.ptr_dec)  ptr_r <= ptr_r - 5'd1;
    if (cmd.ptr_clr)  ptr_r <= '0;
    if (cmd.ptr_inc)  ptr_r <= ptr_r + 5'd1;
  end

  logic [6:0] ch;
  always_comb begin
    unique case (cmd.char_sel)
      ftdt_pkg::CH_MINUS: ch = ftdt_pkg::ASC_MINUS;
      ftdt_pkg::CH_DIGIT: ch = ftdt_pkg::ASC_ZERO + 7'(dg_r[ptr_r]);
      ftdt_pkg::CH_DOT:   ch = ftdt_pkg::ASC_DOT;
      ftdt_pkg::CH_E:     ch = ftdt_pkg::ASC_E;
      ftdt_pkg::CH_TENS:  ch = ftdt_pkg::ASC_ZERO + 7'(ex_tens);
      ftdt_pkg::CH_ONES:  ch = ftdt_pkg::ASC_ZERO + 7'(ex_ones);
      default:            ch = ftdt_pkg::err_char(ptr_r[2:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= ch;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    sts.special   = special_r;
    sts.zero      = zero_r;
    sts.unnorm    = !m_mant_r[ftdt_pkg::MANT_W-1];
    sts.sci       = sci_r;
    sts.lt_tenth  = ftdt_pkg::fl_lt(m_mant_r, m_exp_r,
                                    ftdt_pkg::TENTH_MANT, ftdt_pkg::TENTH_EXP);
    sts.ge_ten    = !ftdt_pkg::fl_lt(m_mant_r, m_exp_r,
                                     ftdt_pkg::TEN_MANT, ftdt_pkg::TEN_EXP);
    sts.lt_one    = ftdt_pkg::fl_lt(m_mant_r, m_exp_r,
                                    ftdt_pkg::ONE_MANT, ftdt_pkg::ONE_EXP);
    sts.p_err     = !zero_r && ftdt_pkg::fl_lt(ftdt_pkg::LIMIT_MANT, ftdt_pkg::LIMIT_EXP,
                                               m_mant_r, m_exp_r);
    sts.div_more  = (nd_r < 5'(ftdt_pkg::DIGIT_SLOTS)) &&
                    ((q_r != '0) || (nd_r <= {1'b0, fd_r}));
    sts.neg       = neg_r;
    sts.ptr_is_fd = (ptr_r == {1'b0, fd_r});
    sts.ptr_zero  = (ptr_r == '0);
    sts.fd_zero   = (fd_r == '0);
    sts.use_exp   = use_exp_r;
    sts.ex_neg    = ex_r[ftdt_pkg::EX_W-1];
    sts.ex_ge10   = (ex_abs >= 6'd10);
    sts.err_end   = (ptr_r == ftdt_pkg::ERR_LAST);
    sts.out_free  = out_free;
  end

  `FTDT_ASSERT_IMP(a_emit_free, cmd.emit, out_free, "character issued into a busy output slot")
  `FTDT_ASSERT_NXT(a_nd_step, cmd.div_step, nd_r == $past(nd_r) + 5'd1, "digit count skipped")
  `FTDT_ASSERT_NXT(a_norm, cmd.mul_load && !zero_r, m_mant_r[23], "multiply result unnormalized")

endmodule

[rtl/ftdt_ctrl.sv]
module ftdt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ftdt_pkg::status_t   sts,
  output ftdt_pkg::cmd_t      cmd
);

  ftdt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ftdt_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == ftdt_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ftdt_pkg::ST_IDLE: if (in_tvalid) state_nxt = ftdt_pkg::ST_PRE;
      ftdt_pkg::ST_PRE: begin
        priority if (sts.special) state_nxt = ftdt_pkg::ST_ERR;
        else if (!sts.zero && sts.unnorm) state_nxt = ftdt_pkg::ST_PRE;
        else if (sts.sci && !sts.zero && sts.lt_tenth) state_nxt = ftdt_pkg::ST_DN_A;
        else if (sts.sci && !sts.zero && sts.ge_ten) state_nxt = ftdt_pkg::ST_UP_A;
        else state_nxt = ftdt_pkg::ST_SC_A;
      end
      ftdt_pkg::ST_DN_A: state_nxt = sts.lt_one ? ftdt_pkg::ST_DN_B : ftdt_pkg::ST_SC_A;
      ftdt_pkg::ST_DN_B: state_nxt = ftdt_pkg::ST_DN_A;
      ftdt_pkg::ST_UP_A: state_nxt = sts.ge_ten ? ftdt_pkg::ST_UP_B : ftdt_pkg::ST_SC_A;
      ftdt_pkg::ST_UP_B: state_nxt = ftdt_pkg::ST_UP_A;
      ftdt_pkg::ST_SC_A: state_nxt = ftdt_pkg::ST_SC_B;
      ftdt_pkg::ST_SC_B: state_nxt = ftdt_pkg::ST_QC;
      ftdt_pkg::ST_QC:   state_nxt = sts.p_err ? ftdt_pkg::ST_ERR : ftdt_pkg::ST_DV_A;
      ftdt_pkg::ST_DV_A: state_nxt = sts.div_more ? ftdt_pkg::ST_DV_B : ftdt_pkg::ST_SIGN;
      ftdt_pkg::ST_DV_B: state_nxt = ftdt_pkg::ST_DV_A;
      ftdt_pkg::ST_SIGN: begin
        if (!sts.neg || sts.out_free) state_nxt = ftdt_pkg::ST_DIG;
      end
      ftdt_pkg::ST_DIG: begin
        if (sts.out_free) begin
          priority if (sts.ptr_is_fd) state_nxt = ftdt_pkg::ST_DOT;
          else if (sts.ptr_zero)
            state_nxt = sts.use_exp ? ftdt_pkg::ST_EXP_E : ftdt_pkg::ST_IDLE;
          else state_nxt = ftdt_pkg::ST_DIG;
        end
      end
      ftdt_pkg::ST_DOT: begin
        if (sts.out_free) begin
          priority if (!sts.fd_zero) state_nxt = ftdt_pkg::ST_DIG;
          else if (sts.use_exp) state_nxt = ftdt_pkg::ST_EXP_E;
          else state_nxt = ftdt_pkg::ST_IDLE;
        end
      end
      ftdt_pkg::ST_EXP_E: if (sts.out_free) state_nxt = ftdt_pkg::ST_EXP_S;
      ftdt_pkg::ST_EXP_S: begin
        if (!sts.ex_neg || sts.out_free) state_nxt = ftdt_pkg::ST_EXP_T;
      end
      ftdt_pkg::ST_EXP_T: begin
        if (!sts.ex_ge10 || sts.out_free) state_nxt = ftdt_pkg::ST_EXP_O;
      end
      ftdt_pkg::ST_EXP_O: if (sts.out_free) state_nxt = ftdt_pkg::ST_IDLE;
      ftdt_pkg::ST_ERR: begin
        if (sts.out_free && sts.err_end) state_nxt = ftdt_pkg::ST_IDLE;
      end
      default: state_nxt = ftdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = ftdt_pkg::MUL_SCALE;
    cmd.char_sel = ftdt_pkg::CH_DIGIT;
    unique case (state_r)
      ftdt_pkg::ST_IDLE: cmd.load = in_tvalid;
      ftdt_pkg::ST_PRE: begin
        priority if (sts.special) cmd.ptr_clr = 1'b1;
        else if (!sts.zero && sts.unnorm) cmd.shift = 1'b1;
        else if (sts.sci && !sts.zero && (sts.lt_tenth || sts.ge_ten)) cmd.set_exp = 1'b1;
        else cmd.set_exp = 1'b0;
      end
      ftdt_pkg::ST_DN_A: cmd.mul_sel = ftdt_pkg::MUL_TEN;
      ftdt_pkg::ST_DN_B: begin
        cmd.mul_sel  = ftdt_pkg::MUL_TEN;
        cmd.mul_load = 1'b1;
        cmd.ex_dec   = 1'b1;
      end
      ftdt_pkg::ST_UP_A: cmd.mul_sel = ftdt_pkg::MUL_TENTH;
      ftdt_pkg::ST_UP_B: begin
        cmd.mul_sel  = ftdt_pkg::MUL_TENTH;
        cmd.mul_load = 1'b1;
        cmd.ex_inc   = 1'b1;
      end
      ftdt_pkg::ST_SC_A: cmd.mul_sel = ftdt_pkg::MUL_SCALE;
      ftdt_pkg::ST_SC_B: cmd.mul_load = 1'b1;
      ftdt_pkg::ST_QC: begin
        if (sts.p_err) cmd.ptr_clr = 1'b1;
        else cmd.q_load = 1'b1;
      end
      ftdt_pkg::ST_DV_A: cmd.ptr_init = !sts.div_more;
      ftdt_pkg::ST_DV_B: cmd.div_step = 1'b1;
      ftdt_pkg::ST_SIGN: begin
        cmd.char_sel = ftdt_pkg::CH_MINUS;
        cmd.emit     = sts.neg && sts.out_free;
      end
      ftdt_pkg::ST_DIG: begin
        cmd.char_sel = ftdt_pkg::CH_DIGIT;
        cmd.emit     = sts.out_free;
        cmd.last     = sts.ptr_zero && !sts.ptr_is_fd && !sts.use_exp;
        cmd.ptr_dec  = sts.out_free && !sts.ptr_zero;
      end
      ftdt_pkg::ST_DOT: begin
        cmd.char_sel = ftdt_pkg::CH_DOT;
        cmd.emit     = sts.out_free;
        cmd.last     = sts.fd_zero && !sts.use_exp;
      end
      ftdt_pkg::ST_EXP_E: begin
        cmd.char_sel = ftdt_pkg::CH_E;
        cmd.emit     = sts.out_free;
      end
      ftdt_pkg::ST_EXP_S: begin
        cmd.char_sel = ftdt_pkg::CH_MINUS;
        cmd.emit     = sts.ex_neg && sts.out_free;
      end
      ftdt_pkg::ST_EXP_T: begin
        cmd.char_sel = ftdt_pkg::CH_TENS;
        cmd.emit     = sts.ex_ge10 && sts.out_free;
      end
      ftdt_pkg::ST_EXP_O: begin
        cmd.char_sel = ftdt_pkg::CH_ONES;
        cmd.emit     = sts.out_free;
        cmd.last     = 1'b1;
      end
      ftdt_pkg::ST_ERR: begin
        cmd.char_sel = ftdt_pkg::CH_ERR;
        cmd.emit     = sts.out_free;
        cmd.last     = sts.err_end;
        cmd.ptr_inc  = sts.out_free && !sts.err_end;
      end
      default: cmd.load = 1'b0;
    endcase
  end

endmodule
